[design/prc_pkg.sv]
// Shared constants and types for the point rotation pipeline.
// No dependencies; prc_sincos, prc_rotate and the top module import this package.
`default_nettype none

package prc_pkg;

	// Q1.14 trig values in a signed 16-bit word
	localparam int TRIG_W      = 16;
	localparam int ONE_Q14     = 16384;
	localparam int ROUND_SHIFT = 14;

	// quarter turn in Q30, source of the sine table
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Taylor series divisors (2n)(2n+1) for the table build
	localparam int TAYLOR_TERMS = 19;
	localparam int unsigned TAYLOR_DIV [1:TAYLOR_TERMS] = '{
		6, 20, 42, 72, 110, 156, 210, 272, 342, 420,
		506, 600, 702, 812, 930, 1056, 1190, 1332, 1482
	};

	// advance strobes for a unit that spans two pipeline stages
	typedef struct packed {
		logic first;
		logic second;
	} stage_en_t;

endpackage

`default_nettype wire

[design/prc_in_if.sv]
// Input channel of the point rotation block: point, center and three angles.
// Standalone interface; carries valid, ready and the payload.
`default_nettype none

interface prc_in_if #(
	parameter int COORD_WIDTH = 16,
	parameter int ANGLE_BITS  = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic signed [COORD_WIDTH-1:0] center_z;
	logic        [ANGLE_BITS-1:0]  angle_x;
	logic        [ANGLE_BITS-1:0]  angle_y;
	logic        [ANGLE_BITS-1:0]  angle_z;

	modport source (
		output valid, point_x, point_y, point_z, center_x, center_y, center_z,
		output angle_x, angle_y, angle_z,
		input  ready
	);

	modport sink (
		input  valid, point_x, point_y, point_z, center_x, center_y, center_z,
		input  angle_x, angle_y, angle_z,
		output ready
	);
endinterface

`default_nettype wire

[design/prc_out_if.sv]
// Output channel of the point rotation block: rotated point and clip flag.
// Standalone interface; carries valid, ready and the payload.
`default_nettype none

interface prc_out_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] out_x;
	logic signed [COORD_WIDTH-1:0] out_y;
	logic signed [COORD_WIDTH-1:0] out_z;
	logic                          clipped;

	modport source (
		output valid, out_x, out_y, out_z, clipped,
		input  ready
	);

	modport sink (
		input  valid, out_x, out_y, out_z, clipped,
		output ready
	);
endinterface

`default_nettype wire

[design/prc_sincos.sv]
// Angle to sine and cosine in Q1.14 over two pipeline stages.
// Holds the quarter-wave table as a constant ROM; uses prc_pkg.
`default_nettype none

module prc_sincos #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic                              clk,
	input  prc_pkg::stage_en_t                en,
	input  logic [ANGLE_BITS-1:0]             angle,
	output logic signed [prc_pkg::TRIG_W-1:0] sine,
	output logic signed [prc_pkg::TRIG_W-1:0] cosine
);
	import prc_pkg::*;

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int POS_W  = ANGLE_BITS - 2;
	localparam int PROD_W = POS_W + IDX_W + 1;
	localparam int ROM_W  = TRIG_W - 1;

	localparam logic [PROD_W-1:0] DEPTH_P = PROD_W'(SINE_TABLE_DEPTH);
	localparam logic [PROD_W-1:0] HALF_P  = PROD_W'(1) << (POS_W - 1);
	localparam logic [IDX_W-1:0]  DEPTH_I = IDX_W'(SINE_TABLE_DEPTH);

	typedef logic [ROM_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

	// one table entry: Taylor series of the sine in Q30, rounded to Q14
	function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k);
		logic [63:0]        th;
		logic [63:0]        th2;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] acc;
		th   = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
		th2  = (th * th) >> 30;
		term = th;
		acc  = signed'(th);
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = ((term * th2) >> 30) / 64'(TAYLOR_DIV[n]);
			if ((n & 1) == 1) begin
				acc = acc - signed'(term);
			end else begin
				acc = acc + signed'(term);
			end
		end
		if (acc < 0) begin
			acc = '0;
		end
		v = (unsigned'(acc) + 64'd32768) >> 16;
		if (v > 64'(ONE_Q14)) begin
			v = 64'(ONE_Q14);
		end
		return v[ROM_W-1:0];
	endfunction

	function automatic rom_t build_rom();
		rom_t r;
		for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
			r[k] = sine_entry(k);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [1:0]        quad;
	logic [1:0]        quad_c;
	logic [POS_W-1:0]  pos;
	logic [PROD_W-1:0] scaled;
	logic [IDX_W:0]    idx_raw;
	logic [IDX_W-1:0]  idx_base;
	logic [IDX_W-1:0]  idx_mirror;

	logic [IDX_W-1:0] sin_idx_s1;
	logic [IDX_W-1:0] cos_idx_s1;
	logic             sin_neg_s1;
	logic             cos_neg_s1;

	logic signed [TRIG_W-1:0] sin_mag;
	logic signed [TRIG_W-1:0] cos_mag;

	// scale the in-quadrant position to the nearest table index
	always_comb begin
		quad       = angle[ANGLE_BITS-1 -: 2];
		quad_c     = quad + 2'd1;
		pos        = angle[POS_W-1:0];
		scaled     = PROD_W'(pos) * DEPTH_P + HALF_P;
		idx_raw    = scaled[PROD_W-1 -: IDX_W + 1];
		idx_base   = (idx_raw > (IDX_W + 1)'(DEPTH_I)) ? DEPTH_I : idx_raw[IDX_W-1:0];
		idx_mirror = DEPTH_I - idx_base;
	end

	// hold mirrored indices and signs for the table read
	always_ff @(posedge clk) begin
		if (en.first) begin
			sin_idx_s1 <= quad[0]   ? idx_mirror : idx_base;
			cos_idx_s1 <= quad_c[0] ? idx_mirror : idx_base;
			sin_neg_s1 <= quad[1];
			cos_neg_s1 <= quad_c[1];
		end
	end

	assign sin_mag = signed'(TRIG_W'(SINE_ROM[sin_idx_s1]));
	assign cos_mag = signed'(TRIG_W'(SINE_ROM[cos_idx_s1]));

	// read the table and apply the quadrant sign
	always_ff @(posedge clk) begin
		if (en.second) begin
			sine   <= sin_neg_s1 ? -sin_mag : sin_mag;
			cosine <= cos_neg_s1 ? -cos_mag : cos_mag;
		end
	end

endmodule

`default_nettype wire

[design/prc_rotate.sv]
// One plane rotation over two stages: four products, then sum and round.
// rot_a = c*a - s*b, rot_b = s*a + c*b, rounded from Q14; uses prc_pkg.
`default_nettype none

module prc_rotate #(
	parameter int A_W = 17,
	parameter int B_W = 17
) (
	input  logic                                 clk,
	input  prc_pkg::stage_en_t                   en,
	input  logic signed [prc_pkg::TRIG_W-1:0]    cos_v,
	input  logic signed [prc_pkg::TRIG_W-1:0]    sin_v,
	input  logic signed [A_W-1:0]                a,
	input  logic signed [B_W-1:0]                b,
	output logic signed [((A_W > B_W) ? A_W : B_W):0] rot_a,
	output logic signed [((A_W > B_W) ? A_W : B_W):0] rot_b
);
	import prc_pkg::*;

	localparam int M_W   = (A_W > B_W) ? A_W : B_W;
	localparam int OUT_W = M_W + 1;
	localparam int P_W   = M_W + TRIG_W;
	localparam int S_W   = P_W + 1;

	localparam logic signed [S_W-1:0] BIAS = S_W'(1) << (ROUND_SHIFT - 1);

	logic signed [P_W-1:0] ca_s1;
	logic signed [P_W-1:0] sb_s1;
	logic signed [P_W-1:0] sa_s1;
	logic signed [P_W-1:0] cb_s1;

	logic signed [S_W-1:0] sum_a;
	logic signed [S_W-1:0] sum_b;

	// register the four products
	always_ff @(posedge clk) begin
		if (en.first) begin
			ca_s1 <= P_W'(cos_v) * P_W'(a);
			sb_s1 <= P_W'(sin_v) * P_W'(b);
			sa_s1 <= P_W'(sin_v) * P_W'(a);
			cb_s1 <= P_W'(cos_v) * P_W'(b);
		end
	end

	// add half an LSB, then floor: nearest, halves toward plus infinity
	always_comb begin
		sum_a = S_W'(ca_s1) - S_W'(sb_s1) + BIAS;
		sum_b = S_W'(sa_s1) + S_W'(cb_s1) + BIAS;
	end

	always_ff @(posedge clk) begin
		if (en.second) begin
			rot_a <= sum_a[OUT_W+ROUND_SHIFT-1:ROUND_SHIFT];
			rot_b <= sum_b[OUT_W+ROUND_SHIFT-1:ROUND_SHIFT];
		end
	end

endmodule

`default_nettype wire

[design/point_rotate_about_center_xyz.sv]
// Rotates a point about a center, about X, then Y, then Z, with saturation.
// Throughput: one beat per cycle while the output is ready; each stage holds
// under backpressure and bubbles collapse, set by the four pipelined
// multipliers of each rotation.
// Reset clears the stage valid bits only; data registers are not reset.
// Depends on prc_pkg, prc_in_if, prc_out_if, prc_sincos and prc_rotate.
`default_nettype none

module point_rotate_about_center_xyz #(
	parameter int COORD_WIDTH      = 16,
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	prc_in_if.sink    items,
	prc_out_if.source results
);
	import prc_pkg::*;

	localparam int NUM_STAGES = 9;
	localparam int D_W = COORD_WIDTH + 1;
	localparam int X_W = COORD_WIDTH + 2;
	localparam int Y_W = COORD_WIDTH + 3;
	localparam int Z_W = COORD_WIDTH + 4;
	localparam int O_W = COORD_WIDTH + 5;
	localparam int C3_W = 3 * COORD_WIDTH;

	localparam logic signed [O_W-1:0] SAT_HI =
		{{(O_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [O_W-1:0] SAT_LO = ~SAT_HI;

	// stage control
	logic [NUM_STAGES:1]   valid_q;
	logic [NUM_STAGES+1:1] adv;

	// coordinate path
	logic signed [D_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [D_W-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [D_W-1:0] dx_s3, dx_s4;
	logic signed [X_W-1:0] xy_s4, xz_s4;
	logic signed [X_W-1:0] xy_s5, xy_s6;
	logic signed [Y_W-1:0] yz_s6, yx_s6;
	logic signed [Y_W-1:0] yz_s7, yz_s8;
	logic signed [Z_W-1:0] zx_s8, zy_s8;

	// centers {x, y, z}, one entry per stage from stage 1 to stage 8
	logic [C3_W-1:0] ctr_s [1:8];

	// trig values
	logic signed [TRIG_W-1:0] sx_s2, cx_s2, sy_s2, cy_s2, sz_s2, cz_s2;
	logic signed [TRIG_W-1:0] sy_s3, cy_s3, sy_s4, cy_s4;
	logic [2*TRIG_W-1:0]      trig_z_s [3:6];

	// output register
	logic signed [COORD_WIDTH-1:0] out_x_s9, out_y_s9, out_z_s9;
	logic                          clip_s9;

	logic signed [O_W-1:0] sum_x, sum_y, sum_z;
	logic [COORD_WIDTH:0]  sat_x, sat_y, sat_z;

	// clamp to the coordinate range; top bit flags a clip
	function automatic logic [COORD_WIDTH:0] saturate(input logic signed [O_W-1:0] v);
		logic [COORD_WIDTH:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, SAT_HI[COORD_WIDTH-1:0]};
		end else if (v < SAT_LO) begin
			r = {1'b1, SAT_LO[COORD_WIDTH-1:0]};
		end else begin
			r = {1'b0, v[COORD_WIDTH-1:0]};
		end
		return r;
	endfunction

	// advance a stage when it is empty or its successor advances
	always_comb begin
		adv[NUM_STAGES+1] = results.ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	assign items.ready   = adv[1];
	assign results.valid = valid_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[1]) begin
				valid_q[1] <= items.valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// stage 1: offset from the center
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dx_s1 <= D_W'(items.point_x) - D_W'(items.center_x);
			dy_s1 <= D_W'(items.point_y) - D_W'(items.center_y);
			dz_s1 <= D_W'(items.point_z) - D_W'(items.center_z);
		end
	end

	// stages 1-2: sine and cosine of each angle
	prc_sincos #(
		.ANGLE_BITS       (ANGLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_trig_x (
		.clk    (clk),
		.en     ('{first: adv[1], second: adv[2]}),
		.angle  (items.angle_x),
		.sine   (sx_s2),
		.cosine (cx_s2)
	);

	prc_sincos #(
		.ANGLE_BITS       (ANGLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_trig_y (
		.clk    (clk),
		.en     ('{first: adv[1], second: adv[2]}),
		.angle  (items.angle_y),
		.sine   (sy_s2),
		.cosine (cy_s2)
	);

	prc_sincos #(
		.ANGLE_BITS       (ANGLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_trig_z (
		.clk    (clk),
		.en     ('{first: adv[1], second: adv[2]}),
		.angle  (items.angle_z),
		.sine   (sz_s2),
		.cosine (cz_s2)
	);

	// stage 2: hold offsets beside the table read
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			dz_s2 <= dz_s1;
		end
	end

	// load the centers, then carry them down to the output stage
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			ctr_s[1] <= {items.center_x, items.center_y, items.center_z};
		end
		for (int k = 2; k <= 8; k++) begin
			if (adv[k]) begin
				ctr_s[k] <= ctr_s[k-1];
			end
		end
	end

	// carry operands of the later rotations
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			dx_s3       <= dx_s2;
			sy_s3       <= sy_s2;
			cy_s3       <= cy_s2;
			trig_z_s[3] <= {sz_s2, cz_s2};
		end
		if (adv[4]) begin
			dx_s4       <= dx_s3;
			sy_s4       <= sy_s3;
			cy_s4       <= cy_s3;
			trig_z_s[4] <= trig_z_s[3];
		end
		if (adv[5]) begin
			xy_s5       <= xy_s4;
			trig_z_s[5] <= trig_z_s[4];
		end
		if (adv[6]) begin
			xy_s6       <= xy_s5;
			trig_z_s[6] <= trig_z_s[5];
		end
		if (adv[7]) begin
			yz_s7 <= yz_s6;
		end
		if (adv[8]) begin
			yz_s8 <= yz_s7;
		end
	end

	// stages 3-4: about X
	prc_rotate #(
		.A_W (D_W),
		.B_W (D_W)
	) u_rot_x (
		.clk   (clk),
		.en    ('{first: adv[3], second: adv[4]}),
		.cos_v (cx_s2),
		.sin_v (sx_s2),
		.a     (dy_s2),
		.b     (dz_s2),
		.rot_a (xy_s4),
		.rot_b (xz_s4)
	);

	// stages 5-6: about Y
	prc_rotate #(
		.A_W (X_W),
		.B_W (D_W)
	) u_rot_y (
		.clk   (clk),
		.en    ('{first: adv[5], second: adv[6]}),
		.cos_v (cy_s4),
		.sin_v (sy_s4),
		.a     (xz_s4),
		.b     (dx_s4),
		.rot_a (yz_s6),
		.rot_b (yx_s6)
	);

	// stages 7-8: about Z
	prc_rotate #(
		.A_W (Y_W),
		.B_W (X_W)
	) u_rot_z (
		.clk   (clk),
		.en    ('{first: adv[7], second: adv[8]}),
		.cos_v (trig_z_s[6][TRIG_W-1:0]),
		.sin_v (trig_z_s[6][2*TRIG_W-1:TRIG_W]),
		.a     (yx_s6),
		.b     (xy_s6),
		.rot_a (zx_s8),
		.rot_b (zy_s8)
	);

	// stage 9: add the center back and saturate
	always_comb begin
		sum_x = O_W'(zx_s8) + O_W'(signed'(ctr_s[8][C3_W-1 -: COORD_WIDTH]));
		sum_y = O_W'(zy_s8) + O_W'(signed'(ctr_s[8][2*COORD_WIDTH-1 -: COORD_WIDTH]));
		sum_z = O_W'(yz_s8) + O_W'(signed'(ctr_s[8][COORD_WIDTH-1:0]));
		sat_x = saturate(sum_x);
		sat_y = saturate(sum_y);
		sat_z = saturate(sum_z);
	end

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			out_x_s9 <= sat_x[COORD_WIDTH-1:0];
			out_y_s9 <= sat_y[COORD_WIDTH-1:0];
			out_z_s9 <= sat_z[COORD_WIDTH-1:0];
			clip_s9  <= sat_x[COORD_WIDTH] | sat_y[COORD_WIDTH] | sat_z[COORD_WIDTH];
		end
	end

	assign results.out_x   = out_x_s9;
	assign results.out_y   = out_y_s9;
	assign results.out_z   = out_z_s9;
	assign results.clipped = clip_s9;

endmodule

`default_nettype wire

[bench/point_rotate_about_center_xyz_test.sv]
// Self-checking bench for point_rotate_about_center_xyz: XYZ rotation about a center point.
// Uses prc_in_if, prc_out_if and the block itself; carries its own sine table and rotation math.
`default_nettype none

module point_rotate_about_center_xyz_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          N_RANDOM     = 1250;
	localparam int          HOLD_AT      = 400;
	localparam int          HOLD_CYCLES  = 240;
	localparam int          DRAIN_CYCLES = 30;
	localparam int          STALL_LIMIT  = 5000;
	localparam int          ROM_DEPTH    = 256;
	localparam longint unsigned QTURN_Q30 = 64'd1686629713;
	localparam longint      UNIT_Q14     = 16384;
	localparam longint      COORD_MAX    = 32767;
	localparam longint      COORD_MIN    = -32768;

	typedef struct packed {
		logic signed [15:0] px, py, pz;
		logic signed [15:0] cx, cy, cz;
		logic        [15:0] ax, ay, az;
	} point_job_t;

	typedef struct packed {
		logic signed [15:0] ox, oy, oz;
		logic               clip;
	} rotated_t;

	typedef struct {
		point_job_t  job;
		int unsigned gap;
		bit          drain;
	} queued_job_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// bench-side copies of the block inputs, known from time zero
	logic       in_valid = 1'b0;
	point_job_t drv      = '0;
	logic       rx_ready = 1'b0;

	queued_job_t job_q[$];
	rotated_t    predicted_q[$];
	int          sine_rom[0:ROM_DEPTH];

	int n_sent     = 0;
	int n_results  = 0;
	int n_clipped  = 0;
	int n_errors   = 0;
	int n_directed = 0;
	int idle_wait  = 0;
	int stall_left = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;
	int quiet      = 0;

	prc_in_if  #(.COORD_WIDTH(16), .ANGLE_BITS(16)) items_bus ();
	prc_out_if #(.COORD_WIDTH(16))                  results_bus ();

	assign items_bus.valid    = in_valid;
	assign items_bus.point_x  = drv.px;
	assign items_bus.point_y  = drv.py;
	assign items_bus.point_z  = drv.pz;
	assign items_bus.center_x = drv.cx;
	assign items_bus.center_y = drv.cy;
	assign items_bus.center_z = drv.cz;
	assign items_bus.angle_x  = drv.ax;
	assign items_bus.angle_y  = drv.ay;
	assign items_bus.angle_z  = drv.az;
	assign results_bus.ready  = rx_ready;

	point_rotate_about_center_xyz #(
		.COORD_WIDTH(16),
		.ANGLE_BITS(16),
		.SINE_TABLE_DEPTH(ROM_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_bus),
		.results(results_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Quarter-wave sine in Q1.14 from a fixed-point Taylor series
	function automatic void build_sine_rom();
		longint unsigned th, th2, term, v, dv;
		longint acc;
		int n;
		for (int k = 0; k <= ROM_DEPTH; k++) begin
			th   = (QTURN_Q30 * longint'(k)) / longint'(ROM_DEPTH);
			th2  = (th * th) >> 30;
			term = th;
			acc  = longint'(th);
			for (n = 1; n < 20 && term != 0; n++) begin
				dv   = longint'(2 * n) * longint'(2 * n + 1);
				term = ((term * th2) >> 30) / dv;
				if (n % 2 == 1)
					acc = acc - longint'(term);
				else
					acc = acc + longint'(term);
			end
			if (acc < 0)
				acc = 0;
			v = (longint'(acc) + 64'd32768) >> 16;
			if (v > longint'(UNIT_Q14))
				v = UNIT_Q14;
			sine_rom[k] = int'(v);
		end
	endfunction

	// Sine of an angle advanced by some quarter turns (one quarter gives cosine)
	function automatic longint turn_sine(logic [15:0] ang, int quarters);
		int quad, pos, idx;
		longint s;
		quad = (int'(ang[15:14]) + quarters) % 4;
		pos  = int'(ang[13:0]);
		idx  = (pos * ROM_DEPTH + (1 << 13)) >> 14;
		if (idx > ROM_DEPTH)
			idx = ROM_DEPTH;
		if (quad % 2 == 1)
			idx = ROM_DEPTH - idx;
		s = sine_rom[idx];
		return (quad >= 2) ? -s : s;
	endfunction

	// Round a Q14 pair sum to nearest, halves toward plus infinity
	function automatic longint drop_q14(longint v);
		return (v + 64'sd8192) >>> 14;
	endfunction

	function automatic logic [15:0] clamp_coord(longint v, inout logic clip);
		if (v > COORD_MAX) begin
			clip = 1'b1;
			return 16'(COORD_MAX);
		end
		if (v < COORD_MIN) begin
			clip = 1'b1;
			return 16'(COORD_MIN);
		end
		return 16'(v);
	endfunction

	function automatic rotated_t rotate_point(point_job_t j);
		longint ccx, ccy, ccz, dx, dy, dz;
		longint sx, cx, sy, cy, sz, cz;
		longint xy, xz, yz, yx, zx, zy;
		rotated_t r;
		logic clip;
		clip = 1'b0;
		ccx  = longint'($signed(j.cx));
		ccy  = longint'($signed(j.cy));
		ccz  = longint'($signed(j.cz));
		dx   = longint'($signed(j.px)) - ccx;
		dy   = longint'($signed(j.py)) - ccy;
		dz   = longint'($signed(j.pz)) - ccz;
		sx = turn_sine(j.ax, 0);
		cx = turn_sine(j.ax, 1);
		sy = turn_sine(j.ay, 0);
		cy = turn_sine(j.ay, 1);
		sz = turn_sine(j.az, 0);
		cz = turn_sine(j.az, 1);
		xy = drop_q14(cx * dy - sx * dz);
		xz = drop_q14(sx * dy + cx * dz);
		yz = drop_q14(cy * xz - sy * dx);
		yx = drop_q14(sy * xz + cy * dx);
		zx = drop_q14(cz * yx - sz * xy);
		zy = drop_q14(sz * yx + cz * xy);
		r.ox   = clamp_coord(zx + ccx, clip);
		r.oy   = clamp_coord(zy + ccy, clip);
		r.oz   = clamp_coord(yz + ccz, clip);
		r.clip = clip;
		return r;
	endfunction

	function automatic point_job_t mk_job(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
			logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
			logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
		point_job_t j;
		j.px = px; j.py = py; j.pz = pz;
		j.cx = cx; j.cy = cy; j.cz = cz;
		j.ax = ax; j.ay = ay; j.az = az;
		return j;
	endfunction

	function automatic void add_job(point_job_t j, int unsigned gap, bit drain);
		queued_job_t q;
		q.job   = j;
		q.gap   = gap;
		q.drain = drain;
		job_q.push_back(q);
	endfunction

	// Feed input beats; predict each one as it is accepted
	always @(posedge clk or negedge arst_n) begin : feed
		bit offering;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			idle_wait <= 0;
		end else begin
			offering = in_valid;
			if (in_valid && items_bus.ready) begin
				predicted_q.push_back(rotate_point(drv));
				n_sent <= n_sent + 1;
				offering = 1'b0;
			end
			if (!offering) begin
				if (job_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idle_wait < job_q[0].gap) begin
					idle_wait <= idle_wait + 1;
					in_valid  <= 1'b0;
				end else if (job_q[0].drain && predicted_q.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					drv       <= job_q[0].job;
					in_valid  <= 1'b1;
					idle_wait <= 0;
					job_q.pop_front();
				end
			end
		end
	end

	// Hold the output side off once, long enough to back the pipeline up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_sent >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Check each result beat against the oldest prediction; throttle ready
	always @(posedge clk or negedge arst_n) begin : watch
		int stall_n;
		rotated_t want;
		int errs;
		if (!arst_n) begin
			rx_ready   <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_n = stall_left;
			if (results_bus.valid && rx_ready) begin
				n_results <= n_results + 1;
				if (results_bus.clipped)
					n_clipped <= n_clipped + 1;
				errs = 0;
				if (predicted_q.size() == 0) begin
					$error("result beat with no prediction pending");
					errs = errs + 1;
				end else begin
					want = predicted_q.pop_front();
					if (results_bus.out_x !== want.ox) begin
						$error("out_x: expected %0d, actual %0d",
							$signed(want.ox), $signed(results_bus.out_x));
						errs = errs + 1;
					end
					if (results_bus.out_y !== want.oy) begin
						$error("out_y: expected %0d, actual %0d",
							$signed(want.oy), $signed(results_bus.out_y));
						errs = errs + 1;
					end
					if (results_bus.out_z !== want.oz) begin
						$error("out_z: expected %0d, actual %0d",
							$signed(want.oz), $signed(results_bus.out_z));
						errs = errs + 1;
					end
					if (results_bus.clipped !== want.clip) begin
						$error("clipped: expected %0d, actual %0d",
							want.clip, results_bus.clipped);
						errs = errs + 1;
					end
				end
				n_errors <= n_errors + errs;
				// stretches of results taken back to back, otherwise random stalls
				stall_n = ((n_results / 150) % 3 == 1) ? 0 : $urandom_range(0, 14);
			end else if (stall_n > 0) begin
				stall_n = stall_n - 1;
			end
			stall_left <= stall_n;
			rx_ready   <= (stall_n == 0) && (hold_left == 0);
		end
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && items_bus.ready) || (results_bus.valid && rx_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		point_job_t j;
		int sel;
		build_sine_rom();

		// directed: identity, quarter/half/full turns, rounding edges, saturation
		add_job(mk_job(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 1'b0);
		add_job(mk_job(16'h0100, 16'h0200, 16'h0300, 0, 0, 0, 0, 0, 0), 0, 1'b0);
		add_job(mk_job(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
			0, 0, 0), $urandom_range(0, 14), 1'b0);
		add_job(mk_job(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			0, 0, 0), 0, 1'b0);
		add_job(mk_job(16'h0100, 0, 0, 0, 0, 0, 16'h4000, 0, 0), 0, 1'b0);
		add_job(mk_job(0, 16'h0100, 0, 0, 0, 0, 16'h4000, 0, 0), 0, 1'b0);
		add_job(mk_job(0, 0, 16'h0100, 0, 0, 0, 0, 16'h4000, 0), $urandom_range(0, 14), 1'b0);
		add_job(mk_job(16'h0100, 0, 0, 0, 0, 0, 0, 0, 16'h4000), 0, 1'b0);
		add_job(mk_job(16'd1000, -16'sd2000, 16'd3000, 16'd100, 16'd200, -16'sd300,
			16'h8000, 16'h8000, 16'h8000), 0, 1'b0);
		add_job(mk_job(16'd1000, -16'sd2000, 16'd3000, 16'd100, 16'd200, -16'sd300,
			16'hC000, 16'hC000, 16'hC000), 0, 1'b0);
		add_job(mk_job(16'h1234, 16'hEDCB, 16'h0F0F, 16'h0011, 16'hFF00, 16'h00F0,
			16'hFFFF, 16'hFFFF, 16'hFFFF), $urandom_range(0, 14), 1'b0);
		add_job(mk_job(16'h1234, 16'hEDCB, 16'h0F0F, 0, 0, 0,
			16'h3FFF, 16'h7FFF, 16'hBFFF), 0, 1'b0);
		add_job(mk_job(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
			16'h2000, 16'h2000, 16'h2000), 0, 1'b0);
		add_job(mk_job(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h2000, 16'h2000, 16'h2000), 0, 1'b0);
		add_job(mk_job(16'h0500, 16'hFB00, 16'h0280, 0, 0, 0,
			16'h0001, 16'h0002, 16'h8001), $urandom_range(0, 14), 1'b0);
		add_job(mk_job(16'd12345, 16'd12345, 16'd12345, 16'd12345, 16'd12345, 16'd12345,
			16'h1234, 16'h1234, 16'h1234), 0, 1'b0);
		add_job(mk_job(16'd1, 16'd1, 16'd1, 0, 0, 0, 16'h2000, 16'h2000, 16'h2000), 0, 1'b0);
		add_job(mk_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0,
			16'h6000, 16'hA000, 16'hE000), 0, 1'b0);
		add_job(mk_job(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
			16'hAAAA, 16'h5555, 16'hAAAA), $urandom_range(0, 14), 1'b0);
		add_job(mk_job(0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h5555, 16'hAAAA, 16'h5555), 0, 1'b0);
		n_directed = job_q.size();

		// random: wide, near-center, quadrant-angle and point-at-center mixes
		for (int i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(0, 9);
			j = mk_job(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
			if (sel >= 5 && sel <= 7) begin
				j.px = 16'($urandom_range(0, 4095)) - 16'd2048;
				j.py = 16'($urandom_range(0, 4095)) - 16'd2048;
				j.pz = 16'($urandom_range(0, 4095)) - 16'd2048;
				j.cx = 16'($urandom_range(0, 4095)) - 16'd2048;
				j.cy = 16'($urandom_range(0, 4095)) - 16'd2048;
				j.cz = 16'($urandom_range(0, 4095)) - 16'd2048;
			end
			if (sel == 8) begin
				j.ax = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
				j.ay = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
				j.az = {2'($urandom_range(0, 3)), 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
			end
			if (sel == 9) begin
				j.px = j.cx;
				j.py = j.cy;
				j.pz = j.cz;
			end
			add_job(j, ((i / 120) % 3 == 2) ? 0 : $urandom_range(0, 14),
				(i == 0) || (i == 700));
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last beat in, every prediction matched, then a short tail
		while (job_q.size() != 0 || in_valid || predicted_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Rotated %0d points (%0d directed, %0d saturated) through one long",
			n_results, n_directed, n_clipped);
		$display("output hold and two full drains; %0d mismatches.", n_errors);
		if (n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
design/prc_pkg.sv
design/prc_in_if.sv
design/prc_out_if.sv
design/prc_sincos.sv
design/prc_rotate.sv
design/point_rotate_about_center_xyz.sv
bench/point_rotate_about_center_xyz_test.sv
